[rtl/core/lcr_pkg.sv]
`timescale 1ns / 1ps

package lcr_pkg;

	// converter word length default
	localparam int DATA_BITS_DEF = 24;

	// fixed field widths
	localparam int RAW_W       = 24;
	localparam int WEIGHT_W    = 32;
	localparam int HALF_W      = 16;
	localparam int TIMEOUT_W   = 24;
	localparam int TARE_W      = 24;
	localparam int COEF_W      = 32;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 64;

	// result beat layout, lowest bit up
	localparam int O_SCK    = 0;
	localparam int O_BUSY   = 1;
	localparam int O_DONE   = 2;
	localparam int O_TMO    = 3;
	localparam int O_RAW_LO = 4;
	localparam int O_WGT_LO = O_RAW_LO + RAW_W;
	localparam int O_USED   = O_WGT_LO + WEIGHT_W;

	// input beat layout
	localparam int I_START = 0;
	localparam int I_DOUT  = 1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TARE        = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE       = 2'd3;

	// register reset values
	localparam logic [HALF_W-1:0]    HALF_RST    = 16'd1;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 24'd200000;
	localparam logic [TARE_W-1:0]    TARE_RST    = 24'd0;
	localparam logic [COEF_W-1:0]    SCALE_RST   = 32'd65536;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_WAIT  = 2'd1,
		PH_CLOCK = 2'd2
	} phase_t;

	// per-tick status flags carried down the pipeline
	typedef struct packed {
		logic sck;
		logic busy;
		logic done;
		logic tmo;
	} flags_t;

endpackage

[rtl/core/load_cell_adc_serial_reader.sv]
`timescale 1ns / 1ps

// Two-wire load-cell converter readout with tare and Q16.16 scaling.
// Slave side: one beat per time-base tick, tdata = {dout, start_req}.
// Master side: one beat per accepted tick with the pin levels to drive and
// the status of that tick; raw_code is nonzero only on a done beat and
// weight holds the last computed value between completions.
// Configuration: cfg_wen/cfg_index/cfg_data, to be written only while idle;
// the block does not enforce this. Throughput: one beat per cycle while the
// master side accepts. Stages: a result beat passes the input register,
// sequencer step plus tare subtract, 25x32 multiply, and round and saturate
// into the output register.
// Timing: a start only enters the wait phase; the pin is checked from the
// next tick. The tick seeing dout low raises sck and is the first high tick.
// The tick ending each of the first 24 low halves samples a bit; the 25th
// pulse sets gain 128 and its low half ends with done. A wait of
// timeout_ticks ticks with the pin high ends in done, timed_out, zero code.
// Reset: all stages empty, sequencer idle, sck low, weight zero, registers
// at defaults. A stalled master side stops the pipeline stage by stage and
// the slave side keeps accepting until every stage holds a beat.
module load_cell_adc_serial_reader #(
	parameter int DATA_BITS = lcr_pkg::DATA_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wen,
	input  logic [lcr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lcr_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [0] start_req, [1] dout, [7:2] zero
	input  logic [lcr_pkg::IN_TDATA_W-1:0]     s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [0] sck, [1] busy_res, [2] done_res, [3] timed_out, [27:4] raw_code,
	// [59:28] weight, [63:60] zero
	output logic [lcr_pkg::OUT_TDATA_W-1:0]    m_tdata
);

	localparam int PULSE_W = $clog2(DATA_BITS + 2);
	localparam int DIFF_W  = lcr_pkg::RAW_W + 1;
	localparam int PROD_W  = DIFF_W + lcr_pkg::COEF_W;
	localparam int Q_W     = PROD_W - 16;

	// configuration
	logic [lcr_pkg::HALF_W-1:0]    half_q;
	logic [lcr_pkg::TIMEOUT_W-1:0] timeout_q;
	logic [lcr_pkg::TARE_W-1:0]    tare_q;
	logic signed [lcr_pkg::COEF_W-1:0] scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q    <= lcr_pkg::HALF_RST;
			timeout_q <= lcr_pkg::TIMEOUT_RST;
			tare_q    <= lcr_pkg::TARE_RST;
			scale_q   <= lcr_pkg::SCALE_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				lcr_pkg::CFG_HALF_PERIOD: half_q    <= cfg_data[lcr_pkg::HALF_W-1:0];
				lcr_pkg::CFG_TIMEOUT:     timeout_q <= cfg_data[lcr_pkg::TIMEOUT_W-1:0];
				lcr_pkg::CFG_TARE:        tare_q    <= cfg_data[lcr_pkg::TARE_W-1:0];
				lcr_pkg::CFG_SCALE:       scale_q   <= cfg_data;
			endcase
		end
	end

	// pipeline handshake
	logic v_s1, v_s2, v_s3, out_valid_q;
	logic rdy1, rdy2, rdy3, rdy_out;

	assign rdy_out  = !out_valid_q || m_tready;
	assign rdy3     = !v_s3 || rdy_out;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign s_tready = rdy1;

	// stage 1: input register
	logic start_s1, dout_s1;

	always_ff @(posedge clk) begin
		if (s_tvalid && rdy1) begin
			start_s1 <= s_tdata[lcr_pkg::I_START];
			dout_s1  <= s_tdata[lcr_pkg::I_DOUT];
		end
	end

	// sequencer state
	lcr_pkg::phase_t phase_q, phase_d;
	logic [lcr_pkg::TIMEOUT_W-1:0] wait_q, wait_d, wait_inc;
	logic [lcr_pkg::HALF_W-1:0]    delay_q, delay_d, delay_inc, half_eff;
	logic [PULSE_W-1:0]            pulse_q, pulse_d, pulse_inc;
	logic                          clk_lvl_q, clk_lvl_d;
	logic [DATA_BITS-1:0]          shift_q, shift_d;
	logic                          done_d, tmo_d;
	logic [lcr_pkg::RAW_W-1:0]     code_d;
	logic                          seq_en;

	assign seq_en    = v_s1 && rdy2;
	assign wait_inc  = wait_q + lcr_pkg::TIMEOUT_W'(1);
	assign delay_inc = delay_q + lcr_pkg::HALF_W'(1);
	assign pulse_inc = pulse_q + PULSE_W'(1);
	assign half_eff  = (half_q == '0) ? lcr_pkg::HALF_W'(1) : half_q;

	always_comb begin
		phase_d   = phase_q;
		wait_d    = wait_q;
		delay_d   = delay_q;
		pulse_d   = pulse_q;
		clk_lvl_d = clk_lvl_q;
		shift_d   = shift_q;
		done_d    = 1'b0;
		tmo_d     = 1'b0;
		code_d    = '0;
		unique case (phase_q)
			lcr_pkg::PH_IDLE: begin
				if (start_s1) begin
					phase_d = lcr_pkg::PH_WAIT;
					wait_d  = '0;
				end
			end
			lcr_pkg::PH_WAIT: begin
				if (!dout_s1) begin
					phase_d   = lcr_pkg::PH_CLOCK;
					clk_lvl_d = 1'b1;
					delay_d   = '0;
					pulse_d   = '0;
					shift_d   = '0;
				end else begin
					wait_d = wait_inc;
					if (wait_inc >= timeout_q) begin
						phase_d = lcr_pkg::PH_IDLE;
						wait_d  = '0;
						done_d  = 1'b1;
						tmo_d   = 1'b1;
					end
				end
			end
			lcr_pkg::PH_CLOCK: begin
				delay_d = delay_inc;
				if (delay_inc >= half_eff) begin
					delay_d = '0;
					if (clk_lvl_q) begin
						clk_lvl_d = 1'b0;
					end else begin
						if (pulse_q < PULSE_W'(DATA_BITS))
							shift_d = {shift_q[DATA_BITS-2:0], dout_s1};
						pulse_d = pulse_inc;
						if (pulse_inc >= PULSE_W'(DATA_BITS + 1)) begin
							phase_d = lcr_pkg::PH_IDLE;
							pulse_d = '0;
							done_d  = 1'b1;
							// offset binary: flip the top data bit
							code_d  = lcr_pkg::RAW_W'(shift_q ^ {1'b1, {(DATA_BITS-1){1'b0}}});
						end else begin
							clk_lvl_d = 1'b1;
						end
					end
				end
			end
			default: begin
				phase_d = lcr_pkg::PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= lcr_pkg::PH_IDLE;
			wait_q    <= '0;
			delay_q   <= '0;
			pulse_q   <= '0;
			clk_lvl_q <= 1'b0;
			shift_q   <= '0;
		end else if (seq_en) begin
			phase_q   <= phase_d;
			wait_q    <= wait_d;
			delay_q   <= delay_d;
			pulse_q   <= pulse_d;
			clk_lvl_q <= clk_lvl_d;
			shift_q   <= shift_d;
		end
	end

	// stage 2: status and tared reading
	lcr_pkg::flags_t           flags_s2;
	logic [lcr_pkg::RAW_W-1:0] code_s2;
	logic signed [DIFF_W-1:0]  diff_s2;

	always_ff @(posedge clk) begin
		if (seq_en) begin
			flags_s2.sck  <= clk_lvl_d;
			flags_s2.busy <= (phase_d != lcr_pkg::PH_IDLE);
			flags_s2.done <= done_d;
			flags_s2.tmo  <= tmo_d;
			code_s2       <= code_d;
			diff_s2       <= $signed({1'b0, code_d}) - $signed({1'b0, tare_q});
		end
	end

	// stage 3: product
	lcr_pkg::flags_t           flags_s3;
	logic [lcr_pkg::RAW_W-1:0] code_s3;
	logic signed [PROD_W-1:0]  prod_s3;

	always_ff @(posedge clk) begin
		if (v_s2 && rdy3) begin
			flags_s3 <= flags_s2;
			code_s3  <= code_s2;
			prod_s3  <= PROD_W'(diff_s2) * PROD_W'(scale_q);
		end
	end

	// divide by 65536 toward zero, then clamp to int32
	logic signed [Q_W-1:0]              q_trunc;
	logic                               q_round_up;
	logic                               q_fits;
	logic signed [lcr_pkg::WEIGHT_W-1:0] wgt_sat, wgt_out;
	logic signed [lcr_pkg::WEIGHT_W-1:0] last_wgt_q;

	assign q_round_up = prod_s3[PROD_W-1] && (prod_s3[15:0] != '0);
	assign q_trunc    = prod_s3[PROD_W-1:16] + $signed({{(Q_W-1){1'b0}}, q_round_up});
	assign q_fits     = (q_trunc[Q_W-1:lcr_pkg::WEIGHT_W-1] == '0) ||
	                    (q_trunc[Q_W-1:lcr_pkg::WEIGHT_W-1] == '1);

	always_comb begin
		if (q_fits)
			wgt_sat = q_trunc[lcr_pkg::WEIGHT_W-1:0];
		else if (q_trunc[Q_W-1])
			wgt_sat = {1'b1, {(lcr_pkg::WEIGHT_W-1){1'b0}}};
		else
			wgt_sat = {1'b0, {(lcr_pkg::WEIGHT_W-1){1'b1}}};
	end

	assign wgt_out = flags_s3.done ? wgt_sat : last_wgt_q;

	logic out_en;
	assign out_en = v_s3 && rdy_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			last_wgt_q <= '0;
		else if (out_en && flags_s3.done)
			last_wgt_q <= wgt_sat;
	end

	// output register
	logic [lcr_pkg::OUT_TDATA_W-1:0] out_data_q;

	always_ff @(posedge clk) begin
		if (out_en) begin
			out_data_q <= lcr_pkg::OUT_TDATA_W'({wgt_out, code_s3, flags_s3.tmo,
				flags_s3.done, flags_s3.busy, flags_s3.sck});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy1)    v_s1        <= s_tvalid;
			if (rdy2)    v_s2        <= v_s1;
			if (rdy3)    v_s3        <= v_s2;
			if (rdy_out) out_valid_q <= v_s3;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

[rtl/core/lcr_checker.sv]
`timescale 1ns / 1ps

module lcr_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [lcr_pkg::OUT_TDATA_W-1:0] m_tdata
);

	logic sck, busy, done, tmo;
	logic [lcr_pkg::RAW_W-1:0] raw;

	assign sck  = m_tdata[lcr_pkg::O_SCK];
	assign busy = m_tdata[lcr_pkg::O_BUSY];
	assign done = m_tdata[lcr_pkg::O_DONE];
	assign tmo  = m_tdata[lcr_pkg::O_TMO];
	assign raw  = m_tdata[lcr_pkg::O_WGT_LO-1:lcr_pkg::O_RAW_LO];

	// a completion always leaves the sequencer idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && done |-> !busy)
		else $error("done beat with busy set");

	a_tmo_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && tmo |-> done && (raw == '0))
		else $error("timeout beat without done or with nonzero code");

	a_code_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !done |-> (raw == '0))
		else $error("raw code outside a done beat");

	// clock line only toggles during a reading
	a_sck_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && sck |-> busy)
		else $error("sck high while idle");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result beat changed");

endmodule

bind load_cell_adc_serial_reader lcr_checker u_lcr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

[verif/load_cell_adc_serial_reader_tb.sv]
`timescale 1ns / 1ps

module load_cell_adc_serial_reader_tb;
	import lcr_pkg::*;

	localparam int WORD_BITS = DATA_BITS_DEF;
	localparam logic [RAW_W-1:0] SIGN_FLIP = RAW_W'(1 << (WORD_BITS - 1));
	localparam int PIPE_LATENCY = 3;
	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 5000;
	localparam longint WEIGHT_MAX = 64'sd2147483647;
	localparam longint WEIGHT_MIN = -64'sd2147483648;

	typedef struct packed {
		logic sck;
		logic busy;
		logic done;
		logic tmo;
		logic [RAW_W-1:0] raw;
		logic [WEIGHT_W-1:0] weight;
	} tick_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	// register shadow
	logic [HALF_W-1:0] half_ticks = HALF_RST;
	logic [TIMEOUT_W-1:0] tmo_ticks = TIMEOUT_RST;
	logic [TARE_W-1:0] tare_reg = TARE_RST;
	logic signed [COEF_W-1:0] scale_reg = SCALE_RST;

	// sequencer shadow
	phase_t seq_phase = PH_IDLE;
	logic [23:0] wait_cnt = '0;
	logic [15:0] delay_cnt = '0;
	logic [4:0] pulse_cnt = '0;
	logic sck_lvl = 1'b0;
	logic [RAW_W-1:0] shift_reg = '0;
	logic [WEIGHT_W-1:0] held_weight = '0;

	tick_result_t sequencer_results[$];
	int failures = 0;
	int items_sent = 0;
	int send_idle_pct = 17;
	int recv_idle_pct = 68;
	bit hold_request = 1'b0;
	int hold_left = 0;

	load_cell_adc_serial_reader uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #6 clk = ~clk;

	function automatic logic [WEIGHT_W-1:0] weigh(input logic [RAW_W-1:0] code);
		longint diff;
		longint prod;
		longint q;
		diff = longint'({40'd0, code}) - longint'({40'd0, tare_reg});
		prod = diff * longint'(scale_reg);
		q = prod / 65536;    // truncates toward zero
		if (q > WEIGHT_MAX)
			q = WEIGHT_MAX;
		else if (q < WEIGHT_MIN)
			q = WEIGHT_MIN;
		return q[WEIGHT_W-1:0];
	endfunction

	function automatic tick_result_t step_sequencer(input logic st, input logic pin);
		tick_result_t r;
		logic [15:0] half;
		r = '0;
		half = (half_ticks == 0) ? 16'd1 : half_ticks;
		case (seq_phase)
			PH_IDLE: begin
				if (st) begin
					seq_phase = PH_WAIT;
					wait_cnt = '0;
				end
			end
			PH_WAIT: begin
				if (!pin) begin
					seq_phase = PH_CLOCK;
					sck_lvl = 1'b1;
					delay_cnt = '0;
					pulse_cnt = '0;
					shift_reg = '0;
				end else begin
					wait_cnt = wait_cnt + 24'd1;
					if (wait_cnt >= tmo_ticks) begin
						seq_phase = PH_IDLE;
						wait_cnt = '0;
						r.done = 1'b1;
						r.tmo = 1'b1;
						held_weight = weigh('0);
					end
				end
			end
			default: begin
				delay_cnt = delay_cnt + 16'd1;
				if (delay_cnt >= half) begin
					delay_cnt = '0;
					if (sck_lvl) begin
						sck_lvl = 1'b0;
					end else begin
						if (pulse_cnt < WORD_BITS)
							shift_reg = {shift_reg[RAW_W-2:0], pin};
						pulse_cnt = pulse_cnt + 5'd1;
						// extra pulse sets gain 128, its low half ends the read
						if (pulse_cnt >= WORD_BITS + 1) begin
							seq_phase = PH_IDLE;
							pulse_cnt = '0;
							r.done = 1'b1;
							r.raw = shift_reg ^ SIGN_FLIP;
							held_weight = weigh(r.raw);
						end else begin
							sck_lvl = 1'b1;
						end
					end
				end
			end
		endcase
		r.sck = sck_lvl;
		r.busy = (seq_phase != PH_IDLE);
		r.weight = held_weight;
		return r;
	endfunction

	task automatic send_tick(input logic st, input logic pin);
		logic [IN_TDATA_W-1:0] beat;
		beat = '0;
		beat[I_START] = st;
		beat[I_DOUT] = pin;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= beat;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sequencer_results.push_back(step_sequencer(st, pin));
		items_sent++;
		@(negedge clk);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (sequencer_results.size() != 0)
			@(negedge clk);
		repeat (PIPE_LATENCY + 8) @(negedge clk);
	endtask

	// all four registers, written back to back with the pipeline drained
	task automatic load_settings(input logic [HALF_W-1:0] half,
			input logic [TIMEOUT_W-1:0] tmo, input logic [TARE_W-1:0] tare,
			input logic [COEF_W-1:0] scale);
		settle();
		cfg_wen <= 1'b1;
		cfg_index <= CFG_HALF_PERIOD;
		cfg_data <= CFG_DATA_W'(half);
		@(negedge clk);
		cfg_index <= CFG_TIMEOUT;
		cfg_data <= CFG_DATA_W'(tmo);
		@(negedge clk);
		cfg_index <= CFG_TARE;
		cfg_data <= CFG_DATA_W'(tare);
		@(negedge clk);
		cfg_index <= CFG_SCALE;
		cfg_data <= scale;
		@(negedge clk);
		cfg_wen <= 1'b0;
		half_ticks = half;
		tmo_ticks = tmo;
		tare_reg = tare;
		scale_reg = scale;
		@(negedge clk);
	endtask

	// one start, ready_delay ticks with the pin high, then the word clocked out
	task automatic run_reading(input logic [RAW_W-1:0] word, input int ready_delay);
		int waited;
		int bit_idx;
		logic pin;
		waited = 0;
		send_tick(1'b1, 1'($urandom_range(1)));
		while (seq_phase != PH_IDLE) begin
			if (seq_phase == PH_WAIT) begin
				pin = (waited < ready_delay);
				waited++;
			end else if (sck_lvl || pulse_cnt >= WORD_BITS) begin
				pin = 1'($urandom_range(1));
			end else begin
				bit_idx = WORD_BITS - 1 - int'(pulse_cnt);
				pin = word[bit_idx];
			end
			// start while busy must be ignored
			send_tick(1'($urandom_range(1)), pin);
		end
		repeat ($urandom_range(3)) send_tick(1'b0, 1'($urandom_range(1)));
	endtask

	task automatic test_default_readout();
		send_idle_pct = 17;
		recv_idle_pct = 68;
		run_reading(24'hFFFFFF, 0);
		run_reading(24'h000000, 3);
	endtask

	task automatic test_register_extremes();
		// zero timeout, largest coefficient
		load_settings(16'd1, 24'd0, 24'd0, 32'h7FFFFFFF);
		run_reading(24'h7FFFFF, 0);
		run_reading(24'h000000, 1);
		// zero half period, full tare, most negative coefficient
		load_settings(16'd0, 24'd2, 24'hFFFFFF, 32'h80000000);
		run_reading(24'h800000, 0);
		run_reading(24'h5A5A5A, 5);
		// longest half period, only timeouts here
		load_settings(16'hFFFF, 24'd1, 24'h123456, 32'hFFFF0000);
		run_reading(24'h000000, 4);
		// longest timeout
		load_settings(16'd2, 24'hFFFFFF, 24'h800000, 32'h00010000);
		run_reading(24'($urandom()), 6);
	endtask

	task automatic test_output_stall();
		load_settings(16'd1, 24'd20, 24'($urandom()), 32'h00010000);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_request = 1'b1;
		repeat (3) run_reading(24'($urandom()), $urandom_range(4));
	endtask

	task automatic test_random_readings();
		int mode_end;
		int round_end;
		int delay;
		logic [HALF_W-1:0] half;
		logic [TIMEOUT_W-1:0] tmo;
		logic [TARE_W-1:0] tare;
		logic [COEF_W-1:0] scale;
		logic [RAW_W-1:0] word;
		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					send_idle_pct = 17;
					recv_idle_pct = 68;
				end
				1: begin
					send_idle_pct = 68;
					recv_idle_pct = 17;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			mode_end = items_sent + 400;
			while (items_sent < mode_end) begin
				half = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 3));
				case ($urandom_range(3))
					0: tmo = '0;
					1: tmo = 24'($urandom_range(1, 30));
					2: tmo = 24'($urandom());
					default: tmo = 24'($urandom_range(1, 8));
				endcase
				case ($urandom_range(3))
					0: tare = '0;
					1: tare = 24'hFFFFFF;
					default: tare = 24'($urandom());
				endcase
				case ($urandom_range(4))
					0: scale = $urandom();
					1: scale = 32'h00010000 + 32'($urandom_range(0, 4096)) - 32'd2048;
					2: scale = $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
					3: scale = 32'($signed(18'($urandom())));
					default: scale = '0;
				endcase
				load_settings(half, tmo, tare, scale);
				round_end = items_sent + 100;
				while (items_sent < round_end) begin
					case ($urandom_range(4))
						0: word = '0;
						1: word = 24'hFFFFFF;
						default: word = 24'($urandom());
					endcase
					if ($urandom_range(4) == 0)
						delay = $urandom_range(0, 40);
					else
						delay = $urandom_range(0, 10);
					run_reading(word, delay);
				end
			end
		end
	endtask

	// receiver: random ready, or a long hold-off on request
	always @(negedge clk) begin
		if (hold_request) begin
			hold_left = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		tick_result_t want;
		tick_result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.sck = m_tdata[O_SCK];
			got.busy = m_tdata[O_BUSY];
			got.done = m_tdata[O_DONE];
			got.tmo = m_tdata[O_TMO];
			got.raw = m_tdata[O_RAW_LO +: RAW_W];
			got.weight = m_tdata[O_WGT_LO +: WEIGHT_W];
			if (sequencer_results.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected beat at %0t: %h", $time, m_tdata);
			end else begin
				want = sequencer_results.pop_front();
				if (got !== want) begin
					failures++;
					if (failures <= 10) begin
						$display("mismatch at %0t: exp sck %b busy %b done %b tmo %b raw %h wgt %0d",
							$time, want.sck, want.busy, want.done, want.tmo, want.raw,
							$signed(want.weight));
						$display("    got sck %b busy %b done %b tmo %b raw %h wgt %0d",
							got.sck, got.busy, got.done, got.tmo, got.raw,
							$signed(got.weight));
					end
				end
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen || !arst_n)
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL load_cell_adc_serial_reader");
		$finish;
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_default_readout();
		test_register_extremes();
		test_output_stall();
		test_random_readings();
		settle();
		if (failures == 0 && sequencer_results.size() == 0) begin
			$display("PASS load_cell_adc_serial_reader");
		end else begin
			$display("FAIL load_cell_adc_serial_reader");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/core/lcr_pkg.sv
rtl/core/load_cell_adc_serial_reader.sv
rtl/core/lcr_checker.sv
verif/load_cell_adc_serial_reader_tb.sv
